// ----- sv/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgc_pkg
// shared types and constants of the button gesture classifier
// ----------------------------------------------------------------------------
package bgc_pkg;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SHORT_LIMIT = 3'd0;
  localparam logic [2:0] REG_LONG_LIMIT  = 3'd1;
  localparam logic [2:0] REG_HOLD_FIRST  = 3'd2;
  localparam logic [2:0] REG_HOLD_SECOND = 3'd3;
  localparam logic [2:0] REG_DOUBLE_GAP  = 3'd4;

  localparam int unsigned ADDR_W = 5;

  // register reset values
  localparam logic [15:0] SHORT_LIMIT_RST = 16'd400;
  localparam logic [15:0] LONG_LIMIT_RST  = 16'd2000;
  localparam logic [15:0] HOLD_FIRST_RST  = 16'd600;
  localparam logic [15:0] HOLD_SECOND_RST = 16'd4000;
  localparam logic [15:0] DOUBLE_GAP_RST  = 16'd600;

  // event codes
  localparam logic [2:0] EV_PRESSED     = 3'd0;
  localparam logic [2:0] EV_REL_SHORT   = 3'd1;
  localparam logic [2:0] EV_REL_MEDIUM  = 3'd2;
  localparam logic [2:0] EV_REL_LONG    = 3'd3;
  localparam logic [2:0] EV_RELEASED    = 3'd4;
  localparam logic [2:0] EV_DOUBLE      = 3'd5;
  localparam logic [2:0] EV_HOLD_FIRST  = 3'd6;
  localparam logic [2:0] EV_HOLD_SECOND = 3'd7;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [15:0] short_limit_ms;
    logic [15:0] long_limit_ms;
    logic [15:0] hold_first_ms;
    logic [15:0] hold_second_ms;
    logic [15:0] double_gap_ms;
  } cfg_t;

  // events caused by one sample, oldest in codes[0]
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][2:0] codes;
  } run_t;

endpackage

// ----- sv/button_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier
// press, release class, double click and hold events from button samples
// ----------------------------------------------------------------------------
// order: the first event of a sample is offered in the cycle after its request is taken
// throughput: one sample per cycle while each causes at most one event and
//   out_ready is high; a run of more events is shifted out of the result
//   register in order, the next sample enters as the last event leaves
// reset: rst synchronous, active high; thresholds to defaults, button released
module button_gesture_classifier (
  input  logic                       clk,
  input  logic                       rst,
  // sample channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bgc_pkg::in_t               in_item,
  // event channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output bgc_pkg::out_t              out_item,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  bgc_pkg::cfg_t cfg;
  bgc_pkg::run_t run;
  logic          in_fire;

  // a request is taken whenever the result register can take its run;
  // samples causing no event still update the button state
  assign in_fire = in_valid && in_ready;

  // threshold registers
  bgc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // button state and compare logic, state advances on each request
  bgc_classifier u_classifier (
    .clk    (clk),
    .rst    (rst),
    .accept (in_fire),
    .item   (in_item),
    .cfg    (cfg),
    .run    (run)
  );

  // result register, one event per cycle while out_ready is high, last_of_run marks the run end
  bgc_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .run       (run),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // an empty result register always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  // a request alongside a pending event only when that event ends its run
  a_ready_only_on_run_end: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_ready && out_item.last_of_run)
    else $error("in_ready high while a run is still being delivered");

  // an event that is not the last of its run is followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last_of_run |=> out_valid)
    else $error("run ended without last_of_run");
`endif

endmodule

// ----- sv/bgc_regs.sv -----
// ----------------------------------------------------------------------------
// bgc_regs
// apb register file holding the five 16-bit timing thresholds
// ----------------------------------------------------------------------------
module bgc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bgc_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_limit_ms <= bgc_pkg::SHORT_LIMIT_RST;
      cfg.long_limit_ms  <= bgc_pkg::LONG_LIMIT_RST;
      cfg.hold_first_ms  <= bgc_pkg::HOLD_FIRST_RST;
      cfg.hold_second_ms <= bgc_pkg::HOLD_SECOND_RST;
      cfg.double_gap_ms  <= bgc_pkg::DOUBLE_GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        bgc_pkg::REG_SHORT_LIMIT: cfg.short_limit_ms <= pwdata[15:0];
        bgc_pkg::REG_LONG_LIMIT:  cfg.long_limit_ms  <= pwdata[15:0];
        bgc_pkg::REG_HOLD_FIRST:  cfg.hold_first_ms  <= pwdata[15:0];
        bgc_pkg::REG_HOLD_SECOND: cfg.hold_second_ms <= pwdata[15:0];
        bgc_pkg::REG_DOUBLE_GAP:  cfg.double_gap_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bgc_pkg::REG_SHORT_LIMIT: prdata = {16'd0, cfg.short_limit_ms};
      bgc_pkg::REG_LONG_LIMIT:  prdata = {16'd0, cfg.long_limit_ms};
      bgc_pkg::REG_HOLD_FIRST:  prdata = {16'd0, cfg.hold_first_ms};
      bgc_pkg::REG_HOLD_SECOND: prdata = {16'd0, cfg.hold_second_ms};
      bgc_pkg::REG_DOUBLE_GAP:  prdata = {16'd0, cfg.double_gap_ms};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/bgc_classifier.sv -----
// ----------------------------------------------------------------------------
// bgc_classifier
// button state registers and the compare logic that turns one sample
// into its run of events
// ----------------------------------------------------------------------------
module bgc_classifier (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  bgc_pkg::in_t  item,
  input  bgc_pkg::cfg_t cfg,
  output bgc_pkg::run_t run
);

  logic        is_down,          is_down_next;
  logic [31:0] change_time,      change_time_next;
  logic [31:0] release_time,     release_time_next;
  logic        first_hold_done,  first_hold_done_next;
  logic        second_hold_done, second_hold_done_next;

  logic        pressed;
  logic [31:0] held;
  logic [31:0] gap;
  logic        hit_first;
  logic        hit_second;
  logic [2:0]  dur_code;

  assign pressed = !item.raw_level;
  assign held    = item.now_ms - change_time;
  assign gap     = item.now_ms - release_time;

  assign hit_first  = !first_hold_done  && (held > {16'd0, cfg.hold_first_ms});
  assign hit_second = !second_hold_done && (held > {16'd0, cfg.hold_second_ms});

  always_comb begin
    if (held < {16'd0, cfg.short_limit_ms}) begin
      dur_code = bgc_pkg::EV_REL_SHORT;
    end else if (held < {16'd0, cfg.long_limit_ms}) begin
      dur_code = bgc_pkg::EV_REL_MEDIUM;
    end else begin
      dur_code = bgc_pkg::EV_REL_LONG;
    end
  end

  always_comb begin
    run                   = '0;
    is_down_next          = is_down;
    change_time_next      = change_time;
    release_time_next     = release_time;
    first_hold_done_next  = first_hold_done;
    second_hold_done_next = second_hold_done;
    if (!is_down) begin
      if (pressed) begin
        run.count             = 2'd1;
        run.codes[0]          = bgc_pkg::EV_PRESSED;
        is_down_next          = 1'b1;
        change_time_next      = item.now_ms;
        first_hold_done_next  = 1'b0;
        second_hold_done_next = 1'b0;
      end
    end else if (!pressed) begin
      run.codes[0] = dur_code;
      run.codes[1] = bgc_pkg::EV_RELEASED;
      run.count    = 2'd2;
      if (gap < {16'd0, cfg.double_gap_ms}) begin
        run.codes[2] = bgc_pkg::EV_DOUBLE;
        run.count    = 2'd3;
      end
      is_down_next      = 1'b0;
      change_time_next  = item.now_ms;
      release_time_next = item.now_ms;
    end else begin
      // both holds in one sample: first then second
      if (hit_first && hit_second) begin
        run.codes[0] = bgc_pkg::EV_HOLD_FIRST;
        run.codes[1] = bgc_pkg::EV_HOLD_SECOND;
        run.count    = 2'd2;
      end else if (hit_first) begin
        run.codes[0] = bgc_pkg::EV_HOLD_FIRST;
        run.count    = 2'd1;
      end else if (hit_second) begin
        run.codes[0] = bgc_pkg::EV_HOLD_SECOND;
        run.count    = 2'd1;
      end
      if (hit_first) begin
        first_hold_done_next = 1'b1;
      end
      if (hit_second) begin
        second_hold_done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_down          <= 1'b0;
      change_time      <= 32'd0;
      release_time     <= 32'd0;
      first_hold_done  <= 1'b0;
      second_hold_done <= 1'b0;
    end else if (accept) begin
      is_down          <= is_down_next;
      change_time      <= change_time_next;
      release_time     <= release_time_next;
      first_hold_done  <= first_hold_done_next;
      second_hold_done <= second_hold_done_next;
    end
  end

endmodule

// ----- sv/bgc_out_buffer.sv -----
// ----------------------------------------------------------------------------
// bgc_out_buffer
// result register holding one run of up to three events, shifted out
// one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module bgc_out_buffer (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  bgc_pkg::run_t run,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output bgc_pkg::out_t out_item
);

  logic [1:0]      cnt;
  logic [2:0][2:0] codes;
  logic            pop;

  assign out_valid            = (cnt != 2'd0);
  assign pop                  = out_valid && out_ready;
  assign out_item.event_code  = codes[0];
  assign out_item.last_of_run = (cnt == 2'd1);
  // a new run may enter once the last event of the current one leaves
  assign can_load             = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= run.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codes <= run.codes;
    end else if (pop) begin
      codes <= {3'd0, codes[2:1]};
    end
  end

endmodule
